### hdl/ilte_pkg.sv
`timescale 1ns / 1ps

package ilte_pkg;

  localparam int CAPACITY   = 64;
  localparam int WORD_WIDTH = 32;

  // Fixed widths of the item fields
  localparam int OP_W      = 3;
  localparam int POS_W     = 7;
  localparam int VAL_W     = 32;
  localparam int CNT_OUT_W = 7;
  localparam int STAT_W    = 2;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_DROP   = 3'd3,
    OP_READ   = 3'd4,
    OP_REMOVE = 3'd5
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RDWAIT,
    S_SHUP,
    S_PUT,
    S_SHDN,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic                 valid;
    logic [VAL_W-1:0]     rd_data;
    status_e              st;
    logic [CNT_OUT_W-1:0] cnt;
    logic                 empty;
  } res_t;

  // 32-bit input value to a stored word (sign-extend or truncate)
  function automatic logic [WORD_WIDTH-1:0] to_word(input logic signed [VAL_W-1:0] v);
    logic signed [63:0] t;
    t = 64'(v);
    return t[WORD_WIDTH-1:0];
  endfunction

  // Stored word back to the 32-bit result field
  function automatic logic [VAL_W-1:0] word_to_out(input logic signed [WORD_WIDTH-1:0] w);
    logic signed [63:0] t;
    t = 64'(w);
    return t[VAL_W-1:0];
  endfunction

endpackage

### hdl/ilte_ram.sv
`timescale 1ns / 1ps

module ilte_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/ilte_seq.sv
`timescale 1ns / 1ps

module ilte_seq (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [ilte_pkg::OP_W-1:0]         op_i,
  input  logic [ilte_pkg::POS_W-1:0]        position_i,
  input  logic signed [ilte_pkg::VAL_W-1:0] value_i,
  output ilte_pkg::res_t                    res_o,
  input  logic                              res_take_i,
  output logic                              mem_we_o,
  output logic [ilte_pkg::ADDR_W-1:0]       mem_waddr_o,
  output logic [ilte_pkg::WORD_WIDTH-1:0]   mem_wdata_o,
  output logic                              mem_re_o,
  output logic [ilte_pkg::ADDR_W-1:0]       mem_raddr_o,
  input  logic [ilte_pkg::WORD_WIDTH-1:0]   mem_rdata_i
);

  import ilte_pkg::*;

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  op_e                   op_q, op_d;
  logic [CMP_W-1:0]      pos_q, pos_d;
  logic [WORD_WIDTH-1:0] w_q, w_d;
  status_e               st_q, st_d;
  logic [VAL_W-1:0]      rd_q, rd_d;
  logic [ADDR_W-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]      k_q, k_d;

  logic [CMP_W-1:0]  cnt_ext;
  logic [CMP_W-1:0]  pos_p1;
  logic [CNT_W-1:0]  cnt_m1;
  logic              full, empty;
  logic              pos_gt, pos_ge, pos_eq, pos_last;
  logic              idx_last, idx_at_pos, keep;

  assign cnt_ext    = CMP_W'(count_q);
  assign pos_p1     = pos_q + CMP_W'(1);
  assign cnt_m1     = count_q - CNT_W'(1);
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign empty      = (count_q == '0);
  assign pos_gt     = (pos_q > cnt_ext);
  assign pos_ge     = (pos_q >= cnt_ext);
  assign pos_eq     = (pos_q == cnt_ext);
  assign pos_last   = (pos_p1 == cnt_ext);
  assign idx_last   = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
  assign idx_at_pos = (CMP_W'(idx_q) == pos_q);
  assign keep       = (mem_rdata_i != w_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        state_d = S_DONE;
        case (op_q)
          OP_INSERT: if (!pos_gt && !full && !pos_eq) state_d = S_SHUP;
          OP_DELETE: if (!pos_ge && !pos_last) state_d = S_SHDN;
          OP_READ:   if (!pos_ge) state_d = S_RDWAIT;
          OP_REMOVE: if (!empty) state_d = S_SCAN;
          default: ;
        endcase
      end
      S_RDWAIT: state_d = S_DONE;
      S_SHUP: begin
        if (idx_at_pos) state_d = S_PUT;
      end
      S_PUT: state_d = S_DONE;
      S_SHDN, S_SCAN: begin
        if (idx_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (res_take_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath control
  always_comb begin
    in_ready_o  = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    count_d     = count_q;
    op_d        = op_q;
    pos_d       = pos_q;
    w_d         = w_q;
    st_d        = st_q;
    rd_d        = rd_q;
    idx_d       = idx_q;
    k_d         = k_q;
    res_o       = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d  = op_e'(op_i);
          pos_d = CMP_W'(position_i);
          w_d   = to_word(value_i);
          st_d  = ST_OK;
          rd_d  = '0;
        end
      end
      S_CHECK: begin
        case (op_q)
          OP_APPEND: begin
            if (full) begin
              st_d = ST_FULL;
            end else begin
              mem_we_o    = 1'b1;
              mem_waddr_o = count_q[ADDR_W-1:0];
              mem_wdata_o = w_q;
              count_d     = count_q + CNT_W'(1);
            end
          end
          OP_INSERT: begin
            if (pos_gt) begin
              st_d = ST_BADPOS;
            end else if (full) begin
              st_d = ST_FULL;
            end else if (pos_eq) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = pos_q[ADDR_W-1:0];
              mem_wdata_o = w_q;
              count_d     = count_q + CNT_W'(1);
            end else begin
              mem_re_o    = 1'b1;
              mem_raddr_o = cnt_m1[ADDR_W-1:0];
              idx_d       = cnt_m1[ADDR_W-1:0];
            end
          end
          OP_DELETE: begin
            if (pos_ge) begin
              st_d = ST_BADPOS;
            end else if (pos_last) begin
              count_d = cnt_m1;
            end else begin
              mem_re_o    = 1'b1;
              mem_raddr_o = pos_p1[ADDR_W-1:0];
              idx_d       = pos_p1[ADDR_W-1:0];
            end
          end
          OP_DROP: begin
            if (empty) st_d = ST_EMPTY;
            else       count_d = cnt_m1;
          end
          OP_READ: begin
            if (pos_ge) begin
              st_d = ST_BADPOS;
            end else begin
              mem_re_o    = 1'b1;
              mem_raddr_o = pos_q[ADDR_W-1:0];
            end
          end
          OP_REMOVE: begin
            if (!empty) begin
              mem_re_o    = 1'b1;
              mem_raddr_o = '0;
              idx_d       = '0;
              k_d         = '0;
            end
          end
          default: ;
        endcase
      end
      S_RDWAIT: rd_d = word_to_out(mem_rdata_i);
      S_SHUP: begin
        // move entry idx up by one, then fetch the one below
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q + ADDR_W'(1);
        mem_wdata_o = mem_rdata_i;
        if (!idx_at_pos) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q - ADDR_W'(1);
          idx_d       = idx_q - ADDR_W'(1);
        end
      end
      S_PUT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = pos_q[ADDR_W-1:0];
        mem_wdata_o = w_q;
        count_d     = count_q + CNT_W'(1);
      end
      S_SHDN: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q - ADDR_W'(1);
        mem_wdata_o = mem_rdata_i;
        if (idx_last) begin
          count_d = cnt_m1;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q + ADDR_W'(1);
          idx_d       = idx_q + ADDR_W'(1);
        end
      end
      S_SCAN: begin
        // compaction: k trails idx, so the write never hits the next read
        if (keep) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = k_q[ADDR_W-1:0];
          mem_wdata_o = mem_rdata_i;
          k_d         = k_q + CNT_W'(1);
        end
        if (idx_last) begin
          count_d = keep ? (k_q + CNT_W'(1)) : k_q;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q + ADDR_W'(1);
          idx_d       = idx_q + ADDR_W'(1);
        end
      end
      S_DONE: begin
        res_o.valid   = 1'b1;
        res_o.rd_data = rd_q;
        res_o.st      = st_q;
        res_o.cnt     = CNT_OUT_W'(count_q);
        res_o.empty   = empty;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    pos_q <= pos_d;
    w_q   <= w_d;
    st_q  <= st_d;
    rd_q  <= rd_d;
    idx_q <= idx_d;
    k_q   <= k_d;
  end

endmodule

### hdl/indexed_list_table_engine_top.sv
`timescale 1ns / 1ps
// Channel  | Handshake                 | Payload
// ---------+---------------------------+---------------------------------------------------
// in       | in_valid_i / in_stall_o   | op_i, position_i, value_i
// out      | out_valid_o / out_stall_i | read_data_o, status_o, entry_count_o, is_empty_o
//
// One item at a time. Append, drop, errors and unused ops finish in the check
// state; read waits for the RAM; insert shifts the entries from position up, then
// writes the value; delete shifts those above position down; remove keeps only
// entries unlike value. Moves step one entry per cycle, one RAM read, one write.
// Unstalled, the result is registered as the sequencer returns to idle. Reset clears
// the count, not the entry RAM. A stalled result holds the sequencer and the input.

module indexed_list_table_engine_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [ilte_pkg::OP_W-1:0]         op_i,
  input  logic [ilte_pkg::POS_W-1:0]        position_i,
  input  logic signed [ilte_pkg::VAL_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [ilte_pkg::VAL_W-1:0] read_data_o,
  output logic [ilte_pkg::STAT_W-1:0]       status_o,
  output logic [ilte_pkg::CNT_OUT_W-1:0]    entry_count_o,
  output logic                              is_empty_o
);

  import ilte_pkg::*;

  res_t                  res;
  logic                  res_take;
  logic                  in_ready;
  logic                  mem_we, mem_re;
  logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
  logic [WORD_WIDTH-1:0] mem_wdata, mem_rdata;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic [VAL_W-1:0]     rd_q;
  status_e              st_q;
  logic [CNT_OUT_W-1:0] cnt_q;
  logic                 empty_q;

  assign in_stall_o = !in_ready;
  assign res_take   = !out_valid_q || !out_stall_i;

  ilte_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .op_i        (op_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .res_o       (res),
    .res_take_i  (res_take),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  ilte_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (WORD_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (res.valid && res_take) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_take) begin
      rd_q    <= res.rd_data;
      st_q    <= res.st;
      cnt_q   <= res.cnt;
      empty_q <= res.empty;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = rd_q;
  assign status_o      = st_q;
  assign entry_count_o = cnt_q;
  assign is_empty_o    = empty_q;

endmodule

### hdl/ilte_chk.sv
`timescale 1ns / 1ps

module ilte_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic [ilte_pkg::OP_W-1:0]         op_i,
  input logic [ilte_pkg::POS_W-1:0]        position_i,
  input logic signed [ilte_pkg::VAL_W-1:0] value_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [ilte_pkg::VAL_W-1:0] read_data_o,
  input logic [ilte_pkg::STAT_W-1:0]       status_o,
  input logic [ilte_pkg::CNT_OUT_W-1:0]    entry_count_o,
  input logic                              is_empty_o
);

  import ilte_pkg::*;

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (entry_count_o == '0)))
    else $error("empty flag disagrees with count");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (entry_count_o <= CNT_OUT_W'(CAPACITY)))
    else $error("count above capacity");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> is_empty_o)
    else $error("empty status on a non-empty list");

  a_read_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (read_data_o != '0) |-> (status_o == ST_OK))
    else $error("read data with error status");

endmodule

bind indexed_list_table_engine_top ilte_chk u_ilte_chk (.*);
